@@ sv/pzs_pkg.sv @@
// ----------------------------------------------------------------------------
// pzs_pkg
// Shared constants, status codes and types of the pedestal zero suppression
// block.
// ----------------------------------------------------------------------------
package pzs_pkg;

    localparam int PED_LEN     = 100;
    localparam int MAX_SAMPLES = 512;

    localparam int SMP_W  = 16;
    localparam int WIRE_W = 9;
    localparam int RIDX_W = 9;
    localparam int SUM_W  = 23;
    localparam int SCL_W  = 24;
    localparam int KCNT_W = 10;
    localparam int ST_W   = 3;
    localparam int THR_W  = 16;
    localparam int MASK_W = 10;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_MASKED   = 3'd1;
    localparam logic [ST_W-1:0] ST_BELOW    = 3'd2;
    localparam logic [ST_W-1:0] ST_SHORT    = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_READ = 3'd5;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_READOUT  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIRE_A    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_WIRE_B    = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 16'd1000;
    localparam logic [MASK_W-1:0] MASK_RESET = 10'd512;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic signed [SMP_W-1:0] min;
        logic [CNT_W-1:0]        cnt;
        logic                    ovf;
    } chan_snap_t;

endpackage

@@ sv/pzs_accum.sv @@
// ----------------------------------------------------------------------------
// pzs_accum
// Running channel state: pedestal sum, minimum, sample count and overflow.
// Gives the state after the current push and the sample store write address.
// ----------------------------------------------------------------------------
module pzs_accum
    import pzs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic                    last,
    input  logic signed [SMP_W-1:0] sample,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output chan_snap_t              snap
);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SMP_W-1:0] MIN_RESET = {1'b0, {(SMP_W-1){1'b1}}};

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SMP_W-1:0] min_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    logic                    cnt_ok;
    logic                    in_ped;
    logic signed [SUM_W:0]   sum_ext;
    logic                    sum_sat;

    always_comb begin
        cnt_ok  = cnt_reg < CNT_W'(MAX_SAMPLES);
        in_ped  = cnt_reg < CNT_W'(PED_LEN);
        sum_ext = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(sample);
        sum_sat = sum_ext[SUM_W] != sum_ext[SUM_W-1];

        snap.sum = sum_reg;
        snap.ovf = ovf_reg | ~cnt_ok;
        if (cnt_ok && in_ped) begin
            if (sum_sat) begin
                snap.sum = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
                snap.ovf = 1'b1;
            end else begin
                snap.sum = sum_ext[SUM_W-1:0];
            end
        end
        snap.cnt = cnt_ok ? cnt_reg + CNT_W'(1) : cnt_reg;
        snap.min = (sample < min_reg) ? sample : min_reg;

        wr_en   = push & cnt_ok;
        wr_addr = cnt_reg[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            min_reg <= MIN_RESET;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (push) begin
            if (last) begin
                sum_reg <= '0;
                min_reg <= MIN_RESET;
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end else begin
                sum_reg <= snap.sum;
                min_reg <= snap.min;
                cnt_reg <= snap.cnt;
                ovf_reg <= snap.ovf;
            end
        end
    end

endmodule

@@ sv/pedestal_zero_suppression.sv @@
// ----------------------------------------------------------------------------
// pedestal_zero_suppression
// Pedestal subtraction and zero suppression of one digitizer channel, with
// readout of pedestal-subtracted samples scaled by the pedestal length.
// A result passes the input, middle and output registers. Throughput: one
// item per cycle unless the output stalls; the sample store has one write
// and one read port and each item uses one of them in its first stage.
// Reset clears the channel state, the decision registers and the valid
// flags and loads the register defaults; the sample store is not cleared.
// ----------------------------------------------------------------------------
module pedestal_zero_suppression
    import pzs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // wire_req [8:0], sample [24:9], read_index [33:25], zero fill above
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // func
    input  logic                   s_tuser,
    input  logic                   s_tlast,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // keep [0], status [3:1], out_wire [12:4], pedestal_sum [35:13],
    // scaled_value [59:36], kept_count [69:60], read_last [70], zero [71]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // kind
    output logic                   m_tuser,

    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam logic signed [SCL_W:0] PED_S = (SCL_W+1)'(PED_LEN);

    logic [THR_W-1:0]  thr_reg;
    logic [MASK_W-1:0] mask_a_reg;
    logic [MASK_W-1:0] mask_b_reg;

    logic                    a_v_reg;
    logic                    a_func_reg;
    logic                    a_last_reg;
    logic [WIRE_W-1:0]       a_wire_reg;
    logic signed [SMP_W-1:0] a_sample_reg;
    logic [RIDX_W-1:0]       a_ridx_reg;

    logic                    b_v_reg;
    logic                    b_func_reg;
    logic [WIRE_W-1:0]       b_wire_reg;
    logic [RIDX_W-1:0]       b_ridx_reg;
    chan_snap_t              b_snap_reg;
    logic signed [SMP_W-1:0] rd_reg;

    logic signed [SUM_W-1:0] final_sum_reg;
    logic [CNT_W-1:0]        final_cnt_reg;

    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    m_tuser_reg;

    logic signed [SMP_W-1:0] store [MAX_SAMPLES];

    logic                    out_ready;
    logic                    b_go;
    logic                    b_free;
    logic                    a_nores;
    logic                    a_go;
    logic                    acc_push;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ADDR_W:0]         rd_pos;
    chan_snap_t              snap;

    logic                    masked;
    logic signed [SCL_W:0]   lhs;
    logic signed [SCL_W:0]   rhs;
    logic [CNT_W-1:0]        kept;
    logic [ST_W-1:0]         dec_status;
    logic [CNT_W-1:0]        ridx_ext;
    logic                    bad_read;
    logic signed [SCL_W:0]   scl_full;
    logic                    keep_n;
    logic [ST_W-1:0]         status_n;
    logic [WIRE_W-1:0]       wire_n;
    logic [SUM_W-1:0]        psum_n;
    logic [SCL_W-1:0]        scaled_n;
    logic [CNT_W-1:0]        kcnt_n;
    logic                    rlast_n;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_RESET;
            mask_a_reg <= MASK_RESET;
            mask_b_reg <= MASK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PEAK_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                CFG_MASK_WIRE_A:    mask_a_reg <= cfg_wdata[MASK_W-1:0];
                CFG_MASK_WIRE_B:    mask_b_reg <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    always_comb begin
        out_ready = ~m_tvalid_reg | m_tready;
        b_go      = b_v_reg & out_ready;
        b_free    = ~b_v_reg | b_go;
        a_nores   = (a_func_reg == FUNC_PUSH) & ~a_last_reg;
        a_go      = a_v_reg & (a_nores | b_free);
        s_tready  = ~a_v_reg | a_go;
        acc_push  = a_go & (a_func_reg == FUNC_PUSH);
        rd_pos    = (ADDR_W+1)'(PED_LEN) + (ADDR_W+1)'(a_ridx_reg);
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (s_tready) begin
            a_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_func_reg   <= s_tuser;
            a_last_reg   <= s_tlast;
            a_wire_reg   <= s_tdata[8:0];
            a_sample_reg <= s_tdata[24:9];
            a_ridx_reg   <= s_tdata[33:25];
        end
    end

    pzs_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (acc_push),
        .last    (a_last_reg),
        .sample  (a_sample_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .snap    (snap)
    );

    // Sample store with registered read. The read data is only taken when
    // the item moves into the middle stage, so pushes that pass underneath
    // a waiting readout do not disturb it.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= a_sample_reg;
        end
        if (a_go && !a_nores) begin
            rd_reg <= store[rd_pos[ADDR_W-1:0]];
        end
    end

    // Middle stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (a_go && !a_nores) begin
            b_v_reg <= 1'b1;
        end else if (b_go) begin
            b_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go && !a_nores) begin
            b_func_reg <= a_func_reg;
            b_wire_reg <= a_wire_reg;
            b_ridx_reg <= a_ridx_reg;
            b_snap_reg <= snap;
        end
    end

    // Decision and readout arithmetic.
    always_comb begin
        masked = ({1'b0, b_wire_reg} == mask_a_reg) || ({1'b0, b_wire_reg} == mask_b_reg);
        lhs    = (SCL_W+1)'(b_snap_reg.sum) - PED_S * (SCL_W+1)'(b_snap_reg.min);
        rhs    = PED_S * (SCL_W+1)'($signed({1'b0, thr_reg}));
        kept   = b_snap_reg.cnt - CNT_W'(PED_LEN);
        if (masked) begin
            dec_status = ST_MASKED;
        end else if (b_snap_reg.ovf) begin
            dec_status = ST_OVERFLOW;
        end else if (b_snap_reg.cnt < CNT_W'(PED_LEN)) begin
            dec_status = ST_SHORT;
        end else if (lhs > rhs) begin
            dec_status = ST_OK;
        end else begin
            dec_status = ST_BELOW;
        end

        ridx_ext = CNT_W'(b_ridx_reg);
        bad_read = ridx_ext >= final_cnt_reg;
        scl_full = PED_S * (SCL_W+1)'(rd_reg) - (SCL_W+1)'(final_sum_reg);

        if (b_func_reg == FUNC_READ) begin
            keep_n   = ~bad_read;
            status_n = bad_read ? ST_BAD_READ : ST_OK;
            wire_n   = '0;
            psum_n   = final_sum_reg;
            scaled_n = bad_read ? '0 : scl_full[SCL_W-1:0];
            kcnt_n   = final_cnt_reg;
            rlast_n  = ~bad_read & ((ridx_ext + CNT_W'(1)) == final_cnt_reg);
        end else begin
            keep_n   = dec_status == ST_OK;
            status_n = dec_status;
            wire_n   = b_wire_reg;
            psum_n   = b_snap_reg.sum;
            scaled_n = '0;
            kcnt_n   = (dec_status == ST_OK) ? kept : '0;
            rlast_n  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            final_sum_reg <= '0;
            final_cnt_reg <= '0;
        end else if (b_go && b_func_reg == FUNC_PUSH) begin
            final_sum_reg <= b_snap_reg.sum;
            final_cnt_reg <= kcnt_n;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= b_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go) begin
            m_tuser_reg <= b_func_reg;
            m_tdata_reg <= {1'b0, rlast_n, KCNT_W'(kcnt_n), scaled_n, psum_n, wire_n,
                            status_n, keep_n};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_read_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_READOUT |->
            m_tdata[3:1] == ST_OK || m_tdata[3:1] == ST_BAD_READ)
        else $error("readout result with a decision status");

    a_decision_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DECISION |->
            m_tdata[59:36] == '0 && !m_tdata[70])
        else $error("decision result carries readout fields");

    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_v_reg)
        else $error("input stalled with an empty input register");

    a_final_range: assert property (@(posedge aclk) disable iff (!aresetn)
        final_cnt_reg <= CNT_W'(MAX_SAMPLES - PED_LEN))
        else $error("kept count beyond the store");
`endif

endmodule

@@ sim/tb_pedestal_zero_suppression.sv @@
// ----------------------------------------------------------------------------
// tb_pedestal_zero_suppression
// Self-checking testbench for the pedestal zero suppression block. A shadow
// copy of the channel state and the sample store computes the decision and
// readout results of every accepted item, and each result leaving the block
// is compared field by field against them. Stimulus is a short directed set
// followed by random channels with interleaved reads under several register
// settings, with random gaps on the input side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_pedestal_zero_suppression;
    import pzs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));
    localparam longint SCL_HI = (longint'(1) << (SCL_W - 1)) - 1;
    localparam longint SCL_LO = -(longint'(1) << (SCL_W - 1));
    localparam int     ITEM_TARGET = 1350;

    typedef struct packed {
        logic                    func;
        logic [WIRE_W-1:0]       wire_no;
        logic signed [SMP_W-1:0] sample;
        logic                    last;
        logic [RIDX_W-1:0]       ridx;
    } adc_item_t;

    typedef struct packed {
        logic                    kind;
        logic                    keep;
        logic [ST_W-1:0]         status;
        logic [WIRE_W-1:0]       wire_no;
        logic signed [SUM_W-1:0] psum;
        logic signed [SCL_W-1:0] scaled;
        logic [KCNT_W-1:0]       kcnt;
        logic                    rlast;
    } zs_out_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PEAK_THRESHOLD;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    adc_item_t adc_item_q[$];
    zs_out_t   zs_out_q[$];
    adc_item_t cur_item;
    int        gap_left = 0;
    int        stall_left = 0;
    int        quiet[2] = '{0, 0};
    int        mismatch_cnt = 0;
    int        n_queued = 0;

    // Shadow of the block's channel state and registers.
    logic signed [SMP_W-1:0] adc_mem [MAX_SAMPLES];
    longint ped_acc = 0;
    int     ch_min = 32767;
    int     ch_cnt = 0;
    bit     ch_ovf = 1'b0;
    longint done_sum = 0;
    int     done_cnt = 0;
    int     peak_thr = THR_RESET;
    int     mask_a = MASK_RESET;
    int     mask_b = MASK_RESET;

    pedestal_zero_suppression u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10;
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
    end

    function automatic void apply_zs_item(adc_item_t it);
        zs_out_t r;
        longint  v;
        longint  lhs;
        r = '0;
        if (it.func == FUNC_READ) begin
            r.kind = KIND_READOUT;
            r.psum = done_sum[SUM_W-1:0];
            r.kcnt = done_cnt[KCNT_W-1:0];
            if (it.ridx >= done_cnt) begin
                r.status = ST_BAD_READ;
            end else begin
                v = PED_LEN * longint'(adc_mem[PED_LEN + it.ridx]) - done_sum;
                if (v > SCL_HI) v = SCL_HI;
                if (v < SCL_LO) v = SCL_LO;
                r.keep   = 1'b1;
                r.status = ST_OK;
                r.scaled = v[SCL_W-1:0];
                r.rlast  = (it.ridx + 1 == done_cnt);
            end
            zs_out_q.insert(zs_out_q.size(), r);
            return;
        end
        if (ch_cnt < MAX_SAMPLES) begin
            adc_mem[ch_cnt] = it.sample;
            if (ch_cnt < PED_LEN) begin
                ped_acc += it.sample;
                if (ped_acc > SUM_HI) begin
                    ped_acc = SUM_HI;
                    ch_ovf = 1'b1;
                end
                if (ped_acc < SUM_LO) begin
                    ped_acc = SUM_LO;
                    ch_ovf = 1'b1;
                end
            end
            ch_cnt++;
        end else begin
            ch_ovf = 1'b1;
        end
        if (it.sample < ch_min) ch_min = it.sample;
        if (!it.last) return;

        lhs = ped_acc - PED_LEN * longint'(ch_min);
        if (it.wire_no == mask_a || it.wire_no == mask_b) r.status = ST_MASKED;
        else if (ch_ovf) r.status = ST_OVERFLOW;
        else if (ch_cnt < PED_LEN) r.status = ST_SHORT;
        else if (lhs > PED_LEN * longint'(peak_thr)) r.status = ST_OK;
        else r.status = ST_BELOW;
        done_sum = ped_acc;
        done_cnt = (r.status == ST_OK) ? ch_cnt - PED_LEN : 0;
        r.kind    = KIND_DECISION;
        r.keep    = (r.status == ST_OK);
        r.wire_no = it.wire_no;
        r.psum    = done_sum[SUM_W-1:0];
        r.kcnt    = done_cnt[KCNT_W-1:0];
        zs_out_q.insert(zs_out_q.size(), r);
        ped_acc = 0;
        ch_min  = 32767;
        ch_cnt  = 0;
        ch_ovf  = 1'b0;
    endfunction

    function automatic void check_zs_out();
        zs_out_t got;
        zs_out_t want;
        got.kind    = m_tuser;
        got.keep    = m_tdata[0];
        got.status  = m_tdata[3:1];
        got.wire_no = m_tdata[12:4];
        got.psum    = m_tdata[35:13];
        got.scaled  = m_tdata[59:36];
        got.kcnt    = m_tdata[69:60];
        got.rlast   = m_tdata[70];
        if (zs_out_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: result with none outstanding: kind %0d status %0d",
                         $realtime, got.kind, got.status);
            return;
        end
        want = zs_out_q.pop_front();
        if (got.kind != want.kind || got.keep != want.keep ||
            got.status != want.status || got.wire_no != want.wire_no ||
            got.psum != want.psum || got.scaled != want.scaled ||
            got.kcnt != want.kcnt || got.rlast != want.rlast) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("%0t: mismatch, expected kind %0d keep %0d status %0d wire %0d",
                         $realtime, want.kind, want.keep, want.status, want.wire_no);
                $display("    sum %0d scaled %0d count %0d read_last %0d",
                         want.psum, want.scaled, want.kcnt, want.rlast);
                $display("  actual kind %0d keep %0d status %0d wire %0d",
                         got.kind, got.keep, got.status, got.wire_no);
                $display("    sum %0d scaled %0d count %0d read_last %0d",
                         got.psum, got.scaled, got.kcnt, got.rlast);
            end
        end
    endfunction

    // Mostly no pause or a short one, a few long ones, and now and then a long
    // stretch without any pause at all.
    function automatic int pause_cycles(int side);
        int r;
        if (quiet[side] > 0) begin
            quiet[side]--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) quiet[side] = $urandom_range(20, 80);
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_zs_item(cur_item);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (adc_item_q.size() != 0) begin
                    cur_item = adc_item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.func;
                    s_tlast  <= cur_item.last;
                    s_tdata  <= {6'b0, cur_item.ridx, cur_item.sample, cur_item.wire_no};
                    gap_left = pause_cycles(0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_zs_out();
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = pause_cycles(1);
            end
        end
    end

    function automatic void queue_item(logic func, logic [WIRE_W-1:0] wire_no,
                                       logic [SMP_W-1:0] sample, logic last,
                                       logic [RIDX_W-1:0] ridx);
        adc_item_t it;
        it.func    = func;
        it.wire_no = wire_no;
        it.sample  = sample;
        it.last    = last;
        it.ridx    = ridx;
        adc_item_q.insert(adc_item_q.size(), it);
        n_queued++;
    endfunction

    function automatic void queue_reads(int avail);
        int n;
        n = $urandom_range(0, 24);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0)
                queue_item(FUNC_READ, WIRE_W'($urandom), SMP_W'($urandom), 1'($urandom),
                           RIDX_W'($urandom_range(0, 511)));
            else
                queue_item(FUNC_READ, WIRE_W'($urandom), SMP_W'($urandom), 1'($urandom),
                           RIDX_W'($urandom_range(0, avail + 1)));
        end
    endfunction

    // Shape 0 is flat, 1 a noisy baseline with one dip, 2 full-range noise.
    // Reads are sprinkled between the samples of the channel being loaded.
    function automatic void queue_channel(int wire_no, int len, int shape);
        int base;
        int noise;
        int depth;
        int dip_at;
        int v;
        base   = int'($urandom_range(0, 40000)) - 20000;
        noise  = $urandom_range(0, 30);
        depth  = ($urandom_range(0, 9) < 7) ? peak_thr + int'($urandom_range(0, 60)) - 30
                                            : $urandom_range(0, 8000);
        dip_at = (len > PED_LEN) ? $urandom_range(PED_LEN, len - 1)
                                 : $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++) begin
            if (shape == 0) v = base;
            else if (shape == 2) v = $signed(16'($urandom));
            else v = base + int'($urandom_range(0, 2 * noise)) - noise;
            if (shape == 1 && i == dip_at) v -= depth;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            queue_item(FUNC_PUSH, WIRE_W'(wire_no), SMP_W'(v), i == len - 1,
                       RIDX_W'($urandom));
            if (i != len - 1 && $urandom_range(0, 99) < 6)
                queue_item(FUNC_READ, WIRE_W'($urandom), SMP_W'($urandom), 1'($urandom),
                           RIDX_W'($urandom_range(0, 40)));
        end
    endfunction

    task automatic apply_settings(int thr, int ma, int mb);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PEAK_THRESHOLD;
        cfg_wdata <= CFG_W'(thr);
        @(posedge aclk);
        cfg_index <= CFG_MASK_WIRE_A;
        cfg_wdata <= CFG_W'(ma);
        @(posedge aclk);
        cfg_index <= CFG_MASK_WIRE_B;
        cfg_wdata <= CFG_W'(mb);
        @(posedge aclk);
        cfg_we <= 1'b0;
        peak_thr = thr;
        mask_a   = ma;
        mask_b   = mb;
    endtask

    task automatic wait_idle();
        while (adc_item_q.size() != 0 || s_tvalid || zs_out_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int len;
        int wire_pick;
        int r;
        int thr;
        int ma;
        int mb;
        foreach (adc_mem[i]) adc_mem[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reads before any channel, and channels too short for a pedestal.
        queue_item(FUNC_READ, 9'd0, 16'h0000, 1'b0, 9'd0);
        queue_item(FUNC_READ, 9'h1FF, 16'hFFFF, 1'b1, 9'h1FF);
        queue_item(FUNC_PUSH, 9'h1FF, 16'h7FFF, 1'b0, 9'h1FF);
        queue_item(FUNC_PUSH, 9'h1FF, 16'h8000, 1'b1, 9'd0);
        queue_item(FUNC_PUSH, 9'd0, 16'h0000, 1'b1, 9'd0);
        wait_idle();

        // Both masks hit, including the extreme wire numbers.
        apply_settings(0, 0, 511);
        queue_item(FUNC_PUSH, 9'd0, 16'd5, 1'b1, 9'd0);
        queue_item(FUNC_PUSH, 9'h1FF, 16'hFFFF, 1'b1, 9'd0);
        queue_item(FUNC_PUSH, 9'd3, 16'h7FFF, 1'b1, 9'd0);
        queue_item(FUNC_READ, 9'd0, 16'd0, 1'b0, 9'd0);
        wait_idle();

        for (int ph = 0; n_queued < ITEM_TARGET; ph++) begin
            if (ph == 0) begin
                apply_settings(65535, 512, 512);
            end else if (ph == 1) begin
                apply_settings(0, 512, 0);
            end else begin
                thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 3000);
                ma  = ($urandom_range(0, 2) == 0) ? 512 : $urandom_range(0, 511);
                mb  = ($urandom_range(0, 2) == 0) ? 512 : $urandom_range(0, 511);
                apply_settings(thr, ma, mb);
            end
            if (ph == 1) begin
                // A flat channel of exactly the pedestal length sits at the
                // threshold of zero; then one channel runs past the store.
                queue_channel($urandom_range(1, 511), PED_LEN, 0);
                queue_reads(2);
                queue_channel($urandom_range(1, 511),
                              $urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6), 1);
                queue_reads(2);
            end
            repeat ($urandom_range(1, 2)) begin
                r = $urandom_range(0, 99);
                if (r < 12) len = $urandom_range(1, PED_LEN - 1);
                else if (r < 20) len = PED_LEN + $urandom_range(0, 1);
                else len = PED_LEN + $urandom_range(2, 45);
                r = $urandom_range(0, 99);
                if (r < 20) wire_pick = mask_a % 512;
                else if (r < 30) wire_pick = mask_b % 512;
                else wire_pick = $urandom_range(0, 511);
                r = $urandom_range(0, 99);
                queue_channel(wire_pick, len, (r < 10) ? 0 : (r < 25) ? 2 : 1);
                queue_reads((len > PED_LEN) ? len - PED_LEN : 0);
            end
            wait_idle();
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && zs_out_q.size() == 0) begin
            $display("** pedestal_zero_suppression: PASSED **");
        end else begin
            $display("** pedestal_zero_suppression: FAILED **");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("** pedestal_zero_suppression: FAILED **");
        $finish;
    end

endmodule

@@ pedestal_zero_suppression.f @@
sv/pzs_pkg.sv
sv/pzs_accum.sv
sv/pedestal_zero_suppression.sv
sim/tb_pedestal_zero_suppression.sv
